// ===== rtl/core/irmf_pkg.sv =====
`timescale 1ns / 1ps
// irmf_pkg: types, constants and helpers for the integer running mean unit
// no dependencies
package irmf_pkg;

    localparam int SAMPLE_BITS = 64;
    localparam int DATA_W      = 64;
    localparam int COUNT_W     = 63;
    localparam int DIV_STEPS   = DATA_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0]       sample_count;
        logic signed [DATA_W-1:0] mean_value;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [COUNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              rem_nz;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [DATA_W-1:0] sext_sample(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = (i < SAMPLE_BITS) ? v[i] : v[SAMPLE_BITS-1];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/irmf_div.sv =====
`timescale 1ns / 1ps
// irmf_div: radix-2 restoring divider, one quotient bit per cycle
// depends on irmf_pkg
module irmf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  irmf_pkg::t_div_req i_req,
    output irmf_pkg::t_div_rsp o_rsp
);
    import irmf_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [DATA_W-1:0]   r_rem, n_rem;
    logic [DATA_W-1:0]   r_quo, n_quo;
    logic [COUNT_W-1:0]  r_dvs, n_dvs;
    logic [DATA_W-1:0]   w_shift;
    logic [DATA_W-1:0]   w_dvs_ext;
    logic                w_ge;

    assign w_shift   = {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
    assign w_dvs_ext = {1'b0, r_dvs};
    assign w_ge      = (w_shift >= w_dvs_ext);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem  = w_ge ? (w_shift - w_dvs_ext) : w_shift;
            n_quo  = {r_quo[DATA_W-2:0], w_ge};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.rem_nz   = (r_rem != '0);
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/core/integer_running_mean_floor_unit.sv =====
`timescale 1ns / 1ps
// integer_running_mean_floor_unit: floor running mean with saturating count
// depends on irmf_pkg and irmf_div
//
//   channel | signals                              | payload
//   --------+--------------------------------------+---------------------------
//   input   | i_in_valid / o_in_ready / i_in_data  | operation, sample
//   output  | o_out_valid / i_out_ready / o_out_data | sample_count, mean_value
//
// an add transaction goes from the idle state through the div state, where the
// 64-step divider runs, to done; a clear or a saturated add goes straight to done
// one transaction at a time: o_in_ready is high only while idle
// the result sits in an output register, so a new transaction can be taken
// while it waits; a stalled output holds the finished result in the done state
// reset clears count, mean and all control state
module integer_running_mean_floor_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  irmf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output irmf_pkg::t_out o_out_data
);
    import irmf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0]   r_mean, n_mean;
    logic                r_neg, n_neg;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    t_div_req            w_req;
    t_div_rsp            w_rsp;
    logic                w_accept;
    logic [DATA_W-1:0]   w_x;
    logic                w_x_ge;
    logic [DATA_W-1:0]   w_q_up;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_x        = sext_sample(i_in_data.sample);
    assign w_x_ge     = ($signed(w_x) >= $signed(r_mean));
    assign w_q_up     = w_rsp.quotient + {{(DATA_W-1){1'b0}}, w_rsp.rem_nz};

    irmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mean      = r_mean;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_req.start    = 1'b0;
        w_req.dividend = w_x_ge ? (w_x - r_mean) : (r_mean - w_x);
        w_req.divisor  = r_count + 1'b1;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.operation == OP_CLEAR) begin
                        n_count = '0;
                        n_mean  = '0;
                        n_state = ST_DONE;
                    end else if (r_count == COUNT_MAX) begin
                        n_state = ST_DONE;
                    end else begin
                        w_req.start = 1'b1;
                        n_count     = r_count + 1'b1;
                        n_neg       = !w_x_ge;
                        n_state     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_rsp.done) begin
                    n_mean  = r_neg ? (r_mean - w_q_up) : (r_mean + w_rsp.quotient);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.sample_count = r_count;
                    n_out.mean_value   = r_mean;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_mean      <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mean      <= n_mean;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== bench/tb_integer_running_mean_floor_unit.sv =====
`timescale 1ns / 1ps
// tb_integer_running_mean_floor_unit: self-checking bench for the floor running mean unit
// depends on irmf_pkg and integer_running_mean_floor_unit; a queue-fed driver,
// a monitor and an in-bench predictor of count and mean compare every result
module tb_integer_running_mean_floor_unit;

    localparam int RANDOM_ITEMS = 1300;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [63:0] SAMPLE_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] SAMPLE_MIN = 64'h8000_0000_0000_0000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           o_in_ready;
    irmf_pkg::t_in  in_data = '0;
    logic           o_out_valid;
    logic           out_ready = 1'b0;
    irmf_pkg::t_out o_out_data;

    irmf_pkg::t_in  pending_items[$];
    irmf_pkg::t_out expected_results[$];

    logic [irmf_pkg::COUNT_W-1:0] run_count = '0;
    logic [63:0]                  run_mean  = '0;

    int n_total = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int send_gap = 0;
    int ready_hold = 0;
    bit long_hold_done = 1'b0;
    int cycle_count = 0;

    integer_running_mean_floor_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // low SAMPLE_BITS bits taken as two's complement
    function automatic logic [63:0] narrow_sample(input logic [63:0] raw);
        logic signed [63:0] t;
        t = raw << (64 - irmf_pkg::SAMPLE_BITS);
        return t >>> (64 - irmf_pkg::SAMPLE_BITS);
    endfunction

    // mean + floor((x - mean) / n), with the difference kept as a 64-bit magnitude
    function automatic logic [63:0] floor_mean_step(input logic [63:0] m,
                                                    input logic [63:0] x,
                                                    input logic [63:0] n);
        logic [63:0] mag;
        logic [63:0] q;
        if ($signed(x) >= $signed(m)) begin
            mag = x - m;
            q = mag / n;
            return m + q;
        end
        mag = m - x;
        q = mag / n;
        if (mag % n != 0) begin
            q = q + 1;
        end
        return m - q;
    endfunction

    function automatic irmf_pkg::t_out fold_transaction(input irmf_pkg::t_in it);
        irmf_pkg::t_out r;
        if (it.operation == irmf_pkg::OP_CLEAR) begin
            run_count = '0;
            run_mean = '0;
        end else if (run_count != irmf_pkg::COUNT_MAX) begin
            run_count = run_count + 1'b1;
            run_mean = floor_mean_step(run_mean, narrow_sample(it.sample), {1'b0, run_count});
        end
        r.sample_count = run_count;
        r.mean_value = run_mean;
        return r;
    endfunction

    task automatic queue_item(input logic op, input logic [63:0] value);
        irmf_pkg::t_in it;
        it.operation = op;
        it.sample = value;
        pending_items.push_back(it);
    endtask

    function automatic logic [63:0] random_sample(input logic [63:0] base);
        logic [63:0] v;
        int d;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: ;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = SAMPLE_MAX;
                    1: v = SAMPLE_MIN;
                    2: v = '0;
                    3: v = '1;
                    default: v = 64'd1;
                endcase
            end
            3: begin
                d = int'($urandom_range(0, 2000)) - 1000;
                v = base + 64'(signed'(d));
            end
            4: begin
                d = int'($urandom_range(0, 100)) - 50;
                v = 64'(signed'(d));
            end
            default: begin
                v = v >> $urandom_range(0, 63);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic bit idle_window(input int n);
        return (n < n_total - 200) && ((n / 100) % 4 != 3);
    endfunction

    task automatic check_result(input irmf_pkg::t_out got);
        irmf_pkg::t_out want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual count %0d mean %0d",
                     $time, got.sample_count, got.mean_value);
            n_errors++;
        end else begin
            want = expected_results.pop_front();
            if (got.sample_count !== want.sample_count) begin
                $display("%0t: sample_count mismatch, expected %0d, actual %0d",
                         $time, want.sample_count, got.sample_count);
                n_errors++;
            end
            if (got.mean_value !== want.mean_value) begin
                $display("%0t: mean_value mismatch, expected %0d, actual %0d",
                         $time, want.mean_value, got.mean_value);
                n_errors++;
            end
        end
        n_checked++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (in_valid) begin
                expected_results.push_back(fold_transaction(in_data));
                n_accepted++;
            end
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_items.size() == 0) begin
                in_valid <= 1'b0;
            end else if (idle_window(n_accepted) && $urandom_range(0, 7) == 0) begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 7);
            end else begin
                in_valid <= 1'b1;
                in_data <= pending_items.pop_front();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            ready_hold <= 0;
        end else begin
            if (out_ready && o_out_valid) begin
                check_result(o_out_data);
            end
            if (ready_hold > 0) begin
                out_ready <= 1'b0;
                ready_hold <= ready_hold - 1;
            end else if (!long_hold_done && n_checked >= 150) begin
                // long back-pressure so the unit fills and drops its input ready
                out_ready <= 1'b0;
                ready_hold <= LONG_HOLD - 1;
                long_hold_done <= 1'b1;
            end else if (idle_window(n_checked) && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                ready_hold <= $urandom_range(0, 7);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int n_rand;
        int run_len;
        logic [63:0] base;

        // directed: extremes, full-range differences, floor toward minus infinity
        queue_item(irmf_pkg::OP_CLEAR, '1);
        queue_item(irmf_pkg::OP_ADD, SAMPLE_MAX);
        queue_item(irmf_pkg::OP_ADD, SAMPLE_MIN);
        queue_item(irmf_pkg::OP_ADD, SAMPLE_MAX);
        queue_item(irmf_pkg::OP_CLEAR, SAMPLE_MIN);
        queue_item(irmf_pkg::OP_ADD, SAMPLE_MIN);
        queue_item(irmf_pkg::OP_ADD, SAMPLE_MAX);
        queue_item(irmf_pkg::OP_ADD, '1);
        queue_item(irmf_pkg::OP_ADD, 64'd1);
        queue_item(irmf_pkg::OP_ADD, '0);
        queue_item(irmf_pkg::OP_CLEAR, 64'h5555_5555_5555_5555);
        queue_item(irmf_pkg::OP_ADD, '1);
        queue_item(irmf_pkg::OP_ADD, '0);
        queue_item(irmf_pkg::OP_ADD, -64'sd7);
        queue_item(irmf_pkg::OP_ADD, 64'd3);
        queue_item(irmf_pkg::OP_ADD, 64'h5555_5555_5555_5555);
        queue_item(irmf_pkg::OP_ADD, 64'haaaa_aaaa_aaaa_aaaa);
        queue_item(irmf_pkg::OP_CLEAR, '0);

        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            queue_item(irmf_pkg::OP_CLEAR, {$urandom, $urandom});
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(0, 20);
            base = {$urandom, $urandom} >> $urandom_range(0, 63);
            for (int i = 0; i < run_len; i++) begin
                queue_item(irmf_pkg::OP_ADD, random_sample(base));
            end
            n_rand += run_len + 1;
        end
        n_total = pending_items.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
